FILE: design/extended_gcd_bezout_defines.svh
// Assertion macros used by the extended GCD controller.
// Depends on nothing; expects clk and rst in the including scope.
`ifndef EXTENDED_GCD_BEZOUT_DEFINES_SVH
`define EXTENDED_GCD_BEZOUT_DEFINES_SVH

// Same-cycle implication.
`define EGCD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define EGCD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/egcd_pkg.sv
// Shared types and constants for the extended GCD block.
// No dependencies.
`default_nettype none
package egcd_pkg;

  localparam int unsigned OPND_W = 31;
  localparam int unsigned COEF_W = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic rem_zero;
  } status_t;

endpackage
`default_nettype wire

FILE: design/egcd_datapath.sv
// Datapath: remainder/coefficient registers, bit-serial divider, output register.
// Depends on egcd_pkg.
`default_nettype none
module egcd_datapath import egcd_pkg::*; #(
  parameter int unsigned DATA_W = 31
) (
  input  wire logic                     clk,
  input  wire logic [OPND_W-1:0]        first_operand,
  input  wire logic [OPND_W-1:0]        second_operand,
  input  wire cmd_t                     cmd,
  output status_t                       status,
  output logic [OPND_W-1:0]             divisor,
  output logic signed [COEF_W-1:0]      coef_first,
  output logic signed [COEF_W-1:0]      coef_second,
  output logic                          zero_error
);

  logic [DATA_W-1:0] a, b;
  logic [DATA_W-1:0] r0, r1, rem, quo;
  logic [COEF_W-1:0] s0, s1, t0, t1, ps, pt;
  logic              swapped, zero;

  logic [DATA_W:0]   shifted, diff;
  logic              qbit;

  assign a = first_operand[DATA_W-1:0];
  assign b = second_operand[DATA_W-1:0];

  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, r1};
  assign qbit    = (shifted >= {1'b0, r1});

  assign status.in_zero  = (a == '0) || (b == '0);
  assign status.rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      swapped <= (a < b);
      zero    <= (a == '0) || (b == '0);
      r0      <= (a < b) ? b : a;
      r1      <= (a < b) ? a : b;
      quo     <= (a < b) ? b : a;
      rem     <= '0;
      s0      <= COEF_W'(1);
      s1      <= '0;
      t0      <= '0;
      t1      <= COEF_W'(1);
      ps      <= '0;
      pt      <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], 1'b0};
      ps  <= {ps[COEF_W-2:0], 1'b0} + (qbit ? s1 : '0);
      pt  <= {pt[COEF_W-2:0], 1'b0} + (qbit ? t1 : '0);
    end else if (cmd.update) begin
      r0  <= r1;
      r1  <= rem;
      quo <= r1;
      rem <= '0;
      s0  <= s1;
      s1  <= s0 - ps;
      t0  <= t1;
      t1  <= t0 - pt;
      ps  <= '0;
      pt  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      zero_error <= zero;
      if (zero) begin
        divisor     <= '0;
        coef_first  <= '0;
        coef_second <= '0;
      end else begin
        divisor     <= OPND_W'(r0);
        coef_first  <= swapped ? t0 : s0;
        coef_second <= swapped ? s0 : t0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/egcd_ctrl.sv
// Controller: sequences load, divide bits, coefficient update and output.
// Depends on egcd_pkg and extended_gcd_bezout_defines.svh.
`default_nettype none
`include "extended_gcd_bezout_defines.svh"
module egcd_ctrl import egcd_pkg::*; #(
  parameter int unsigned DATA_W    = 31,
  parameter int unsigned MAX_STEPS = 46
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cmd_t         cmd,
  input  wire status_t status
);

  localparam int unsigned BCW = $clog2(DATA_W);
  localparam int unsigned SCW = $clog2(MAX_STEPS);
  localparam logic [BCW-1:0] BIT_LAST  = BCW'(DATA_W - 1);
  localparam logic [SCW-1:0] STEP_LAST = SCW'(MAX_STEPS - 1);

  state_t         state, state_next;
  logic [BCW-1:0] bit_cnt, bit_cnt_next;
  logic [SCW-1:0] step_cnt, step_cnt_next;
  logic           out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_cnt   <= '0;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bit_cnt   <= bit_cnt_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    bit_cnt_next  = bit_cnt;
    step_cnt_next = step_cnt;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = 1'b1;
          bit_cnt_next  = '0;
          step_cnt_next = '0;
          state_next    = status.in_zero ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == BIT_LAST) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update    = 1'b1;
        bit_cnt_next  = '0;
        step_cnt_next = step_cnt + 1'b1;
        if (status.rem_zero || step_cnt == STEP_LAST) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = cmd.load_out | (out_valid & ~out_ready);
  end

  // held result is never overwritten
  `EGCD_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid || out_ready,
    "result register overwritten while held")
  // zero operand skips the division loop
  `EGCD_ASSERT_NEXT(a_zero_skip, in_valid && in_ready && status.in_zero,
    state == S_DONE, "zero operand did not go straight to output")
  // an update always follows a full division pass
  `EGCD_ASSERT_NOW(a_upd_after_div, state == S_UPD,
    $past(state) == S_DIV && $past(bit_cnt) == BIT_LAST,
    "coefficient update without completed division")

endmodule
`default_nettype wire

FILE: design/extended_gcd_bezout.sv
// Extended GCD with Bezout coefficients, one item at a time.
// Each item runs k quotient steps (at most MAX_STEPS), each a pass of the bit-serial
// divider over the operand width plus one coefficient update; a zero operand skips
// the division. The next item is taken only after the result loads, and the result
// waits to load while a held result has not yet been taken.
// Reset (rst, synchronous): controller idles, output valid clears.
`default_nettype none
module extended_gcd_bezout import egcd_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 31,
  parameter int unsigned MAX_STEPS     = 46
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [OPND_W-1:0]       first_operand,
  input  wire logic [OPND_W-1:0]       second_operand,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [OPND_W-1:0]            divisor,
  output logic signed [COEF_W-1:0]     coef_first,
  output logic signed [COEF_W-1:0]     coef_second,
  output logic                         zero_error
);

  localparam int unsigned DATA_W = (OPERAND_WIDTH < OPND_W) ? OPERAND_WIDTH : OPND_W;

  cmd_t    cmd;
  status_t status;

  egcd_ctrl #(
    .DATA_W    (DATA_W),
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  egcd_datapath #(
    .DATA_W (DATA_W)
  ) u_datapath (
    .clk            (clk),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .cmd            (cmd),
    .status         (status),
    .divisor        (divisor),
    .coef_first     (coef_first),
    .coef_second    (coef_second),
    .zero_error     (zero_error)
  );

endmodule
`default_nettype wire

FILE: sim/extended_gcd_bezout_tb.sv
// Self-checking testbench for extended_gcd_bezout: drives operand pairs, predicts
// gcd and Bezout coefficients, and checks every result transfer in order.
// Depends on egcd_pkg and the extended_gcd_bezout RTL.
`timescale 1ns / 1ps
module extended_gcd_bezout_tb;
  import egcd_pkg::*;

  localparam int unsigned GCD_STEP_LIMIT = 46;
  localparam int unsigned N_RANDOM       = 400;
  localparam int unsigned DRAIN_CYCLES   = 1600;
  localparam logic [OPND_W-1:0] OPND_MAX = '1;

  typedef struct {
    logic [OPND_W-1:0] first;
    logic [OPND_W-1:0] second;
  } operand_pair_t;

  typedef struct {
    logic [OPND_W-1:0]        divisor;
    logic signed [COEF_W-1:0] coef_first;
    logic signed [COEF_W-1:0] coef_second;
    logic                     zero_error;
  } bezout_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OPND_W-1:0]        first_operand = '0;
  logic [OPND_W-1:0]        second_operand = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [OPND_W-1:0]        divisor;
  logic signed [COEF_W-1:0] coef_first;
  logic signed [COEF_W-1:0] coef_second;
  logic                     zero_error;

  operand_pair_t operand_queue[$];
  bezout_t       bezout_queue[$];
  int unsigned   n_items;
  int unsigned   n_accepted = 0;
  int unsigned   n_errors = 0;
  int unsigned   send_idle = 0;
  int unsigned   recv_stall = 0;
  bit            calm_in = 1'b0;
  bit            calm_out = 1'b0;

  extended_gcd_bezout i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .divisor        (divisor),
    .coef_first     (coef_first),
    .coef_second    (coef_second),
    .zero_error     (zero_error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Extended Euclid on (larger, smaller), 64-bit wrapping coefficients,
  // mapped back to operand order.
  function automatic bezout_t compute_bezout(input logic [OPND_W-1:0] a,
                                             input logic [OPND_W-1:0] b);
    bezout_t     res;
    logic [63:0] r0, r1, s0, s1, t0, t1, q, nr, ns, nt;
    logic        swap;
    int unsigned n;
    res.divisor     = '0;
    res.coef_first  = '0;
    res.coef_second = '0;
    res.zero_error  = 1'b0;
    if (a == '0 || b == '0) begin
      res.zero_error = 1'b1;
      return res;
    end
    swap = (a < b);
    r0 = swap ? 64'(b) : 64'(a);
    r1 = swap ? 64'(a) : 64'(b);
    s0 = 64'd1;
    s1 = 64'd0;
    t0 = 64'd0;
    t1 = 64'd1;
    n = 0;
    while (n < GCD_STEP_LIMIT && r1 != 64'd0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      ns = s0 - q * s1;
      nt = t0 - q * t1;
      r0 = r1;
      r1 = nr;
      s0 = s1;
      s1 = ns;
      t0 = t1;
      t1 = nt;
      n++;
    end
    res.divisor     = r0[OPND_W-1:0];
    res.coef_first  = swap ? t0[COEF_W-1:0] : s0[COEF_W-1:0];
    res.coef_second = swap ? s0[COEF_W-1:0] : t0[COEF_W-1:0];
    return res;
  endfunction

  function automatic int unsigned idle_length(input bit calm);
    int unsigned sel;
    if (calm) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(0, 3);
    if (sel < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [OPND_W-1:0] fib(input int unsigned idx);
    longint unsigned f0, f1, tmp;
    f0 = 64'd0;
    f1 = 64'd1;
    for (int unsigned k = 1; k < idx; k++) begin
      tmp = f0 + f1;
      f0  = f1;
      f1  = tmp;
    end
    return f1[OPND_W-1:0];
  endfunction

  task automatic add_pair(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
    operand_pair_t p;
    p.first  = a;
    p.second = b;
    operand_queue.push_back(p);
  endtask

  task automatic add_either(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
    if ($urandom_range(0, 1) != 0) add_pair(a, b);
    else add_pair(b, a);
  endtask

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_idle = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        bezout_queue.push_back(compute_bezout(first_operand, second_operand));
        n_accepted++;
        if ($urandom_range(0, 15) == 0) calm_in = ~calm_in;
      end
      if (send_idle > 0 || operand_queue.size() == 0) begin
        if (send_idle > 0) send_idle--;
        in_valid <= 1'b0;
      end else begin
        operand_pair_t p;
        p = operand_queue.pop_front();
        in_valid       <= 1'b1;
        first_operand  <= p.first;
        second_operand <= p.second;
        send_idle = idle_length(calm_in);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (bezout_queue.size() == 0) begin
          $display("%0t: unexpected result transfer: divisor %0d", $time, divisor);
          n_errors++;
        end else begin
          bezout_t exp_res;
          exp_res = bezout_queue.pop_front();
          if (divisor !== exp_res.divisor) begin
            $display("%0t: divisor expected %0d, got %0d", $time, exp_res.divisor, divisor);
            n_errors++;
          end
          if (coef_first !== exp_res.coef_first) begin
            $display("%0t: coef_first expected %0d, got %0d", $time,
                     exp_res.coef_first, coef_first);
            n_errors++;
          end
          if (coef_second !== exp_res.coef_second) begin
            $display("%0t: coef_second expected %0d, got %0d", $time,
                     exp_res.coef_second, coef_second);
            n_errors++;
          end
          if (zero_error !== exp_res.zero_error) begin
            $display("%0t: zero_error expected %0b, got %0b", $time,
                     exp_res.zero_error, zero_error);
            n_errors++;
          end
        end
        if ($urandom_range(0, 7) == 0) calm_out = ~calm_out;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!calm_out && $urandom_range(0, 7) == 0) begin
        recv_stall = idle_length(1'b0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned       sel;
    int unsigned       idx;
    logic [OPND_W-1:0] g, x, y;

    // zero operands
    add_pair('0, '0);
    add_pair('0, OPND_W'(5));
    add_pair(OPND_W'(7), '0);
    add_pair('0, OPND_MAX);
    add_pair(OPND_MAX, '0);
    // equal operands
    add_pair(OPND_MAX, OPND_MAX);
    add_pair(OPND_W'(1), OPND_W'(1));
    add_pair(OPND_W'(6), OPND_W'(6));
    // smaller divides larger, both orders
    add_pair(OPND_MAX, OPND_W'(1));
    add_pair(OPND_W'(1), OPND_MAX);
    add_pair(OPND_W'(12), OPND_W'(4));
    add_pair(OPND_W'(4), OPND_W'(12));
    add_pair(31'h4000_0000, 31'h0000_8000);
    // general and longest quotient chains
    add_pair(OPND_W'(240), OPND_W'(46));
    add_pair(OPND_W'(46), OPND_W'(240));
    add_pair(fib(46), fib(45));
    add_pair(fib(45), fib(46));
    add_pair(OPND_MAX, OPND_MAX - 1'b1);
    add_pair(OPND_MAX, 31'h4000_0000);
    add_pair(31'h5555_5555, 31'h2AAA_AAAA);
    add_pair(OPND_W'(1234567890), OPND_W'(987654321));

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        add_pair(OPND_W'($urandom), OPND_W'($urandom));
      end else if (sel < 50) begin
        g = OPND_W'($urandom_range(1, 65535));
        x = OPND_W'($urandom_range(1, 32767));
        y = OPND_W'($urandom_range(1, 32767));
        add_pair(g * x, g * y);
      end else if (sel < 60) begin
        g = OPND_W'($urandom_range(1, 1 << 20));
        x = OPND_W'($urandom_range(1, 2047));
        add_either(g, g * x);
      end else if (sel < 70) begin
        add_pair(OPND_W'($urandom_range(1, 255)), OPND_W'($urandom_range(1, 255)));
      end else if (sel < 75) begin
        x = OPND_W'($urandom);
        add_pair(x, x);
      end else if (sel < 80) begin
        idx = $urandom_range(0, 2);
        x = OPND_W'($urandom);
        if (idx == 0) add_pair('0, x);
        else if (idx == 1) add_pair(x, '0);
        else add_pair('0, '0);
      end else if (sel < 90) begin
        idx = $urandom_range(2, 45);
        add_either(fib(idx + 1), fib(idx));
      end else begin
        add_either(OPND_W'($urandom), OPND_W'($urandom_range(1, 1000)));
      end
    end
    n_items = operand_queue.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (!(n_accepted == n_items && bezout_queue.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && bezout_queue.size() == 0) begin
      $display("extended_gcd_bezout_tb: PASS");
    end else begin
      $display("extended_gcd_bezout_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("%0t: timeout", $time);
    $display("extended_gcd_bezout_tb: FAIL");
    $finish;
  end

endmodule
